FILE: hw/rtl/mbsp_pkg.sv
// Shared types and constants for the MIDI byte stream parser.
// Used by mbsp_decode and midi_byte_stream_parser; depends on nothing.

package mbsp_pkg;

   // Event kinds carried on rsp_tuser
   localparam logic [2:0] KIND_NOTE_ON  = 3'd0;
   localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
   localparam logic [2:0] KIND_CONTROL  = 3'd2;
   localparam logic [2:0] KIND_PROGRAM  = 3'd3;
   localparam logic [2:0] KIND_BEND     = 3'd4;
   localparam logic [2:0] KIND_CLOCK    = 3'd5;
   localparam logic [2:0] KIND_START    = 3'd6;
   localparam logic [2:0] KIND_STOP     = 3'd7;

   // Real-time bytes that bypass the parse state
   localparam logic [7:0] RT_CLOCK = 8'hF8;
   localparam logic [7:0] RT_START = 8'hFA;
   localparam logic [7:0] RT_STOP  = 8'hFC;

   // Upper nibble of the status byte
   localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
   localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
   localparam logic [3:0] TYPE_CONTROL  = 4'hB;
   localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
   localparam logic [3:0] TYPE_PRESSURE = 4'hD;
   localparam logic [3:0] TYPE_BEND     = 4'hE;

   localparam logic [13:0] BEND_CENTER = 14'd8192;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 3;
   localparam int CSR_DATA_W  = 4;

   typedef struct packed {
      logic [7:0] running_status;  // zero: no status held
      logic       data_count;      // one data byte of a two-byte message held
      logic [6:0] held_first;      // meaningful only while data_count is set
   } parse_state_type;

   typedef struct packed {
      logic [2:0]         event_kind;
      logic [3:0]         channel;
      logic [6:0]         first_data;
      logic [6:0]         second_data;
      logic signed [13:0] bend_value;
      logic               channel_match;
   } event_type;

endpackage

FILE: hw/rtl/mbsp_decode.sv
// Combinational byte decode: next parse state and the event a byte completes.
// Depends on mbsp_pkg.

module mbsp_decode (
   input  logic [7:0]               rx_byte,
   input  logic [3:0]               listen_channel,
   input  mbsp_pkg::parse_state_type state_cur,
   output mbsp_pkg::parse_state_type state_nxt,
   output logic                     event_valid,
   output mbsp_pkg::event_type      event_out
);

   logic [3:0] rs_type;
   logic       one_byte;
   logic [6:0] d1;
   logic [6:0] d2;

   assign rs_type  = state_cur.running_status[7:4];
   assign one_byte = (rs_type inside {mbsp_pkg::TYPE_PROGRAM, mbsp_pkg::TYPE_PRESSURE});
   assign d1       = one_byte ? rx_byte[6:0] : state_cur.held_first;
   assign d2       = one_byte ? 7'd0 : rx_byte[6:0];

   always_comb begin
      state_nxt   = state_cur;
      event_valid = 1'b0;
      event_out   = '0;
      case (rx_byte)
         mbsp_pkg::RT_CLOCK: begin
            event_valid          = 1'b1;
            event_out.event_kind = mbsp_pkg::KIND_CLOCK;
         end
         mbsp_pkg::RT_START: begin
            event_valid          = 1'b1;
            event_out.event_kind = mbsp_pkg::KIND_START;
         end
         mbsp_pkg::RT_STOP: begin
            event_valid          = 1'b1;
            event_out.event_kind = mbsp_pkg::KIND_STOP;
         end
         default: begin
            if (rx_byte[7]) begin
               state_nxt.running_status = rx_byte;
               state_nxt.data_count     = 1'b0;
            end else if (state_cur.running_status != 8'd0) begin
               if (!one_byte && !state_cur.data_count) begin
                  // hold the first of two data bytes
                  state_nxt.held_first = rx_byte[6:0];
                  state_nxt.data_count = 1'b1;
               end else begin
                  state_nxt.data_count    = 1'b0;
                  event_out.channel       = state_cur.running_status[3:0];
                  event_out.first_data    = d1;
                  event_out.second_data   = d2;
                  event_out.channel_match = (state_cur.running_status[3:0] == listen_channel);
                  event_valid             = 1'b1;
                  case (rs_type)
                     mbsp_pkg::TYPE_NOTE_ON:  event_out.event_kind = mbsp_pkg::KIND_NOTE_ON;
                     mbsp_pkg::TYPE_NOTE_OFF: event_out.event_kind = mbsp_pkg::KIND_NOTE_OFF;
                     mbsp_pkg::TYPE_CONTROL:  event_out.event_kind = mbsp_pkg::KIND_CONTROL;
                     mbsp_pkg::TYPE_PROGRAM:  event_out.event_kind = mbsp_pkg::KIND_PROGRAM;
                     mbsp_pkg::TYPE_BEND: begin
                        event_out.event_kind = mbsp_pkg::KIND_BEND;
                        event_out.bend_value = $signed({d2, d1} - mbsp_pkg::BEND_CENTER);
                     end
                     default: begin
                        // channel pressure and system types complete silently
                        event_valid = 1'b0;
                        event_out   = '0;
                     end
                  endcase
               end
            end
         end
      endcase
   end

endmodule

FILE: hw/rtl/midi_byte_stream_parser.sv
// Top level of the serial MIDI byte stream parser with running status.
// Depends on mbsp_pkg and mbsp_decode.
//
//  channel | direction | payload
//  --------+-----------+-------------------------------------------------------
//  req     | in        | tdata[7:0] rx_byte
//  rsp     | out       | tuser[2:0] event_kind; tdata channel, first, second,
//          |           |   bend_value, channel_match (zero padded to 40 bits)
//  csr     | in        | wdata[3:0] listen_channel, always ready
//
// One byte per cycle sustained unless a stalled rsp blocks an event: a byte is
// registered on transfer, decoded against the parse state while it sits in the
// input register, and its event lands in the output register, which drives
// rsp_tvalid.
// Reset clears running_status and data_count of the parse state, listen_channel
// and both valid flags. A stalled rsp holds the output register; a byte waiting
// in the input register moves on anyway when it produces no event.

module midi_byte_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [mbsp_pkg::REQ_TDATA_W-1:0] req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] channel, [10:4] first_data, [17:11] second_data,
   // [31:18] bend_value, [32] channel_match, [39:33] zero
   output logic [mbsp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [mbsp_pkg::RSP_TUSER_W-1:0] rsp_tuser,   // [2:0] event_kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [mbsp_pkg::CSR_DATA_W-1:0]  csr_wdata     // [3:0] listen_channel
);

   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_byte_ff;
   logic                      out_valid_ff, out_valid_in;
   mbsp_pkg::event_type       out_event_ff;
   mbsp_pkg::parse_state_type state_ff, state_in;
   logic [3:0]                listen_ff;

   logic                      event_valid;
   mbsp_pkg::event_type       event_dec;
   logic                      out_free;
   logic                      advance;
   logic                      req_xfer;

   mbsp_decode u_decode (
      .rx_byte        (in_byte_ff),
      .listen_channel (listen_ff),
      .state_cur      (state_ff),
      .state_nxt      (state_in),
      .event_valid    (event_valid),
      .event_out      (event_dec)
   );

   assign out_free    = !out_valid_ff || rsp_tready;
   assign advance     = in_valid_ff && (out_free || !event_valid);
   assign req_tready  = !in_valid_ff || advance;
   assign req_xfer    = req_tvalid && req_tready;
   assign in_valid_in = req_xfer || (in_valid_ff && !advance);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = advance && event_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff              <= 1'b0;
         out_valid_ff             <= 1'b0;
         state_ff.running_status  <= 8'd0;
         state_ff.data_count      <= 1'b0;
         listen_ff                <= 4'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff.running_status <= state_in.running_status;
            state_ff.data_count     <= state_in.data_count;
            state_ff.held_first     <= state_in.held_first;
         end
         if (csr_valid) begin
            listen_ff <= csr_wdata;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && event_valid && out_free) begin
         out_event_ff <= event_dec;
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_event_ff.event_kind;
   assign rsp_tdata  = {7'd0, out_event_ff.channel_match, out_event_ff.bend_value,
                        out_event_ff.second_data, out_event_ff.first_data,
                        out_event_ff.channel};

endmodule
